### src/cst_pkg.sv
// cst_pkg: shared types, constants and helper functions of the character stream tokenizer
// used by the token channel interface, the scan core, the token queue and the top level
package cst_pkg;

  // sizing
  localparam int POSITION_BITS = 16;
  localparam int LENGTH_BITS   = 8;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);

  // token kinds
  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_UNKNOWN = 5'd1;
  localparam logic [4:0] KIND_LPAREN  = 5'd2;
  localparam logic [4:0] KIND_RPAREN  = 5'd3;
  localparam logic [4:0] KIND_LBRACK  = 5'd4;
  localparam logic [4:0] KIND_RBRACK  = 5'd5;
  localparam logic [4:0] KIND_LBRACE  = 5'd6;
  localparam logic [4:0] KIND_RBRACE  = 5'd7;
  localparam logic [4:0] KIND_SEMI    = 5'd8;
  localparam logic [4:0] KIND_PLUS    = 5'd9;
  localparam logic [4:0] KIND_MINUS   = 5'd10;
  localparam logic [4:0] KIND_STAR    = 5'd11;
  localparam logic [4:0] KIND_SLASH   = 5'd12;
  localparam logic [4:0] KIND_EQ_EQ   = 5'd13;
  localparam logic [4:0] KIND_ASSIGN  = 5'd14;
  localparam logic [4:0] KIND_NUMBER  = 5'd21;
  localparam logic [4:0] KIND_IDENT   = 5'd25;

  // keyword prefix tracking
  localparam logic [2:0] KW_NONE  = 3'd0;
  localparam logic [2:0] KW_PRINT = 3'd1;
  localparam logic [2:0] KW_IF    = 3'd2;
  localparam logic [2:0] KW_ELSE  = 3'd3;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;

  // scanner modes; the four operator modes share bit 2
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_NUMBER = 4'd1,
    MODE_WORD   = 4'd2,
    MODE_DOT    = 4'd3,
    MODE_OP_EQ  = 4'd4,
    MODE_OP_LT  = 4'd5,
    MODE_OP_GT  = 4'd6,
    MODE_OP_NOT = 4'd7
  } scan_mode_t;

  typedef struct packed {
    logic [4:0]               kind;
    logic [POSITION_BITS-1:0] line;
    logic [POSITION_BITS-1:0] column;
    logic [7:0]               length;
    logic [7:0]               bad_byte;
    logic                     last;
  } token_t;

  // tokens handed from the scan core to the queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  // kind of a single-character token, KIND_END when the byte is not one
  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    k = KIND_END;
    case (c)
      8'h28: k = KIND_LPAREN;
      8'h29: k = KIND_RPAREN;
      8'h5B: k = KIND_LBRACK;
      8'h5D: k = KIND_RBRACK;
      8'h7B: k = KIND_LBRACE;
      8'h7D: k = KIND_RBRACE;
      8'h3B: k = KIND_SEMI;
      8'h2B: k = KIND_PLUS;
      8'h2D: k = KIND_MINUS;
      8'h2A: k = KIND_STAR;
      8'h2F: k = KIND_SLASH;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] kw_length(input logic [2:0] prog);
    logic [2:0] n;
    case (prog)
      KW_PRINT: n = 3'd5;
      KW_IF:    n = 3'd2;
      KW_ELSE:  n = 3'd4;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  // character at a position inside a keyword
  function automatic logic [7:0] kw_char(input logic [2:0] prog, input logic [2:0] idx);
    logic [7:0] ch;
    ch = CH_NUL;
    case (prog)
      KW_PRINT: begin
        case (idx)
          3'd0: ch = 8'h70;
          3'd1: ch = 8'h72;
          3'd2: ch = 8'h69;
          3'd3: ch = 8'h6E;
          3'd4: ch = 8'h74;
          default: ch = CH_NUL;
        endcase
      end
      KW_IF: begin
        case (idx)
          3'd0: ch = 8'h69;
          3'd1: ch = 8'h66;
          default: ch = CH_NUL;
        endcase
      end
      KW_ELSE: begin
        case (idx)
          3'd0: ch = 8'h65;
          3'd1: ch = 8'h6C;
          3'd2: ch = 8'h73;
          3'd3: ch = 8'h65;
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // lexeme length as reported, saturating at 255
  function automatic logic [7:0] report_length(input logic [LENGTH_BITS-1:0] len);
    logic [7:0] r;
    if (32'(len) > 32'd255) begin
      r = 8'hFF;
    end else begin
      r = 8'(len);
    end
    return r;
  endfunction

endpackage

### src/cst_in_if.sv
// cst_in_if: character request channel of the tokenizer
// depends on nothing
interface cst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

### src/cst_out_if.sv
// cst_out_if: token request channel of the tokenizer
// depends on cst_pkg for the position width
interface cst_out_if import cst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [4:0]               token_kind;
  logic [POSITION_BITS-1:0] token_line;
  logic [POSITION_BITS-1:0] start_column;
  logic [7:0]               lexeme_length;
  logic [7:0]               unknown_byte;
  logic                     last_of_run;

  modport source (output valid, output token_kind, output token_line, output start_column,
                  output lexeme_length, output unknown_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_line, input start_column,
                  input lexeme_length, input unknown_byte, input last_of_run,
                  output ready);
endinterface

### src/cst_scan_core.sv
// cst_scan_core: scanner mode machine, position counters and token generation
// depends on cst_pkg; produces up to two tokens per accepted character
module cst_scan_core import cst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output push_t      push
);

  scan_mode_t               mode, mode_next;
  logic                     seen_dot, seen_dot_next;
  logic [2:0]               kw_prog, kw_prog_next;
  logic [POSITION_BITS-1:0] cur_line, cur_line_next;
  logic [POSITION_BITS-1:0] cur_col, cur_col_next;
  logic [POSITION_BITS-1:0] tok_line, tok_line_next;
  logic [POSITION_BITS-1:0] tok_col, tok_col_next;
  logic [LENGTH_BITS-1:0]   tok_len, tok_len_next;

  logic [7:0] c;
  logic       is_digit, is_alpha, is_space, is_op_start, is_word_start, is_dot;
  logic       eot, mode_op, cont_number, cont_word, dot_digit, op_pair, fresh;
  logic [1:0] op_idx;
  logic [4:0] one_kind;
  logic       idle_emit, kw_keep;
  logic [POSITION_BITS-1:0] moved_line, moved_col;
  logic [LENGTH_BITS-1:0]   grown_len;
  token_t     flush_tok, second_tok;
  logic       flush_v, second_v;

  // character classes
  assign c             = text_byte;
  assign is_digit      = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha      = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_space      = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  assign is_op_start   = (c == CH_EQ) || (c == CH_LT) || (c == CH_GT) || (c == CH_BANG);
  assign is_word_start = is_alpha || (c == CH_UNDER);
  assign is_dot        = (c == CH_DOT);
  assign one_kind      = single_kind(c);

  // which path this character takes
  assign eot         = end_of_text || (c == CH_NUL);
  assign mode_op     = mode[2];
  assign op_idx      = mode[1:0];
  assign cont_number = (mode == MODE_NUMBER) && (is_digit || (is_dot && !seen_dot));
  assign cont_word   = (mode == MODE_WORD) && (is_word_start || is_digit);
  assign dot_digit   = (mode == MODE_DOT) && is_digit;
  assign op_pair     = mode_op && (c == CH_EQ);
  assign fresh       = !eot && !cont_number && !cont_word && !dot_digit && !op_pair;
  assign idle_emit   = (one_kind != KIND_END) ||
                       (!is_space && !is_op_start && !is_digit && !is_dot && !is_word_start);

  // keyword prefix still matching after this character
  assign kw_keep = (kw_prog != KW_NONE) && (kw_prog <= KW_ELSE) &&
                   (32'(tok_len) < 32'(kw_length(kw_prog))) &&
                   (kw_char(kw_prog, tok_len[2:0]) == c);

  // position after consuming the character, saturating
  assign moved_line = (c == CH_LF && cur_line != POS_MAX) ? cur_line + POS_ONE : cur_line;
  assign moved_col  = (c == CH_LF) ? POS_ONE :
                      (cur_col != POS_MAX) ? cur_col + POS_ONE : cur_col;
  assign grown_len  = (tok_len != LEN_MAX) ? tok_len + LEN_ONE : tok_len;

  // next state
  always_comb begin
    mode_next     = mode;
    seen_dot_next = seen_dot;
    kw_prog_next  = kw_prog;
    cur_line_next = cur_line;
    cur_col_next  = cur_col;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    tok_len_next  = tok_len;
    if (take) begin
      if (eot) begin
        mode_next     = MODE_IDLE;
        seen_dot_next = 1'b0;
        kw_prog_next  = KW_NONE;
        cur_line_next = POS_ONE;
        cur_col_next  = POS_ONE;
        tok_line_next = POS_ONE;
        tok_col_next  = POS_ONE;
        tok_len_next  = '0;
      end else begin
        cur_line_next = moved_line;
        cur_col_next  = moved_col;
        if (cont_number) begin
          seen_dot_next = seen_dot || is_dot;
          tok_len_next  = grown_len;
        end else if (cont_word) begin
          kw_prog_next = kw_keep ? kw_prog : KW_NONE;
          tok_len_next = grown_len;
        end else if (dot_digit) begin
          mode_next     = MODE_NUMBER;
          seen_dot_next = 1'b1;
          tok_len_next  = grown_len;
        end else if (op_pair) begin
          mode_next    = MODE_IDLE;
          tok_len_next = '0;
        end else begin
          // close any open token, then look at the character afresh
          mode_next     = MODE_IDLE;
          seen_dot_next = 1'b0;
          kw_prog_next  = KW_NONE;
          tok_len_next  = '0;
          if (one_kind == KIND_END && (is_op_start || is_digit || is_dot || is_word_start)) begin
            tok_line_next = cur_line;
            tok_col_next  = cur_col;
            tok_len_next  = LEN_ONE;
            if (is_op_start) begin
              mode_next = (c == CH_EQ) ? MODE_OP_EQ :
                          (c == CH_LT) ? MODE_OP_LT :
                          (c == CH_GT) ? MODE_OP_GT : MODE_OP_NOT;
            end else if (is_digit) begin
              mode_next = MODE_NUMBER;
            end else if (is_dot) begin
              mode_next = MODE_DOT;
            end else begin
              mode_next    = MODE_WORD;
              kw_prog_next = (c == 8'h70) ? KW_PRINT :
                             (c == 8'h69) ? KW_IF :
                             (c == 8'h65) ? KW_ELSE : KW_NONE;
            end
          end
        end
      end
    end
  end

  // token that closes the pending lexeme
  always_comb begin
    flush_tok          = '0;
    flush_tok.line     = tok_line;
    flush_tok.column   = tok_col;
    flush_tok.length   = 8'd1;
    case (mode)
      MODE_NUMBER: begin
        flush_tok.kind   = KIND_NUMBER;
        flush_tok.length = report_length(tok_len);
      end
      MODE_WORD: begin
        flush_tok.kind   = KIND_IDENT;
        flush_tok.length = report_length(tok_len);
        if (kw_prog != KW_NONE && kw_prog <= KW_ELSE &&
            32'(tok_len) == 32'(kw_length(kw_prog))) begin
          flush_tok.kind = KIND_NUMBER + 5'(kw_prog);
        end
      end
      MODE_DOT: begin
        flush_tok.kind     = KIND_UNKNOWN;
        flush_tok.bad_byte = CH_DOT;
      end
      MODE_OP_EQ, MODE_OP_LT, MODE_OP_GT, MODE_OP_NOT: begin
        flush_tok.kind = KIND_ASSIGN + 5'({op_idx, 1'b0});
      end
      default: begin
        flush_tok.kind = KIND_END;
      end
    endcase
  end

  // token raised by the character itself
  always_comb begin
    second_tok        = '0;
    second_tok.line   = cur_line;
    second_tok.column = cur_col;
    second_tok.length = 8'd1;
    second_tok.last   = 1'b1;
    if (eot) begin
      second_tok.kind   = KIND_END;
      second_tok.length = 8'd0;
    end else if (op_pair) begin
      second_tok.kind   = KIND_EQ_EQ + 5'({op_idx, 1'b0});
      second_tok.line   = tok_line;
      second_tok.column = tok_col;
      second_tok.length = 8'd2;
    end else if (one_kind != KIND_END) begin
      second_tok.kind = one_kind;
    end else begin
      second_tok.kind     = KIND_UNKNOWN;
      second_tok.bad_byte = c;
    end
  end

  // order the tokens and mark the final one
  assign flush_v  = take && (eot || fresh) && (mode != MODE_IDLE);
  assign second_v = take && (eot || op_pair || (fresh && idle_emit));

  always_comb begin
    push.count  = 2'(flush_v) + 2'(second_v);
    push.second = second_tok;
    if (flush_v) begin
      push.first      = flush_tok;
      push.first.last = !second_v;
    end else begin
      push.first = second_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      seen_dot <= 1'b0;
      kw_prog  <= KW_NONE;
      cur_line <= POS_ONE;
      cur_col  <= POS_ONE;
      tok_line <= POS_ONE;
      tok_col  <= POS_ONE;
      tok_len  <= '0;
    end else begin
      mode     <= mode_next;
      seen_dot <= seen_dot_next;
      kw_prog  <= kw_prog_next;
      cur_line <= cur_line_next;
      cur_col  <= cur_col_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      tok_len  <= tok_len_next;
    end
  end

endmodule

### src/cst_token_queue.sv
// cst_token_queue: small result queue taking up to two tokens a cycle, giving one
// depends on cst_pkg and cst_out_if
module cst_token_queue import cst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  output logic             has_room,
  cst_out_if.source        token_out
);

  token_t                    entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_BITS:0]   fill;
  logic                      pop;

  // room for two tokens keeps a new request flowing every cycle
  assign has_room = (32'(fill) <= QUEUE_DEPTH - 2);
  assign pop      = token_out.valid && token_out.ready;

  // head of the queue drives the channel
  assign token_out.valid         = (fill != '0);
  assign token_out.token_kind    = entries[rd_ptr].kind;
  assign token_out.token_line    = entries[rd_ptr].line;
  assign token_out.start_column  = entries[rd_ptr].column;
  assign token_out.lexeme_length = entries[rd_ptr].length;
  assign token_out.unknown_byte  = entries[rd_ptr].bad_byte;
  assign token_out.last_of_run   = entries[rd_ptr].last;

  // storage writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QUEUE_PTR_BITS'(1)] <= push.second;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(pop);
      fill   <= fill + (QUEUE_PTR_BITS+1)'(push.count) - (QUEUE_PTR_BITS+1)'(pop);
    end
  end

endmodule

### src/char_stream_tokenizer.sv
// char_stream_tokenizer: streaming lexer, one character request per cycle while the token queue has room
// output: a token is registered into the token queue when the character that ends it is taken
// throughput: one character a cycle while the queue has room; a character closing one token and raising another
//   queues two tokens, drained one a cycle while token_out is ready through a four-entry token queue
// reset: synchronous, scanner idle at line 1 column 1, token queue empty
module char_stream_tokenizer import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  cst_in_if.sink      char_in,
  cst_out_if.source   token_out
);

  push_t push;
  logic  has_room;
  logic  take;

  // character request handshake
  assign char_in.ready = has_room;
  assign take          = char_in.valid && char_in.ready;

  cst_scan_core u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .text_byte   (char_in.text_byte),
    .end_of_text (char_in.end_of_text),
    .push        (push)
  );

  cst_token_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .has_room  (has_room),
    .token_out (token_out)
  );

  // no tokens without an accepted character
  assert property (@(posedge clk) disable iff (rst) !take |-> push.count == 2'd0)
    else $error("tokens pushed without an accepted character");

  // end of text always ends with the end token
  assert property (@(posedge clk) disable iff (rst)
    take && (char_in.end_of_text || char_in.text_byte == CH_NUL) |->
      (push.count == 2'd1 && push.first.kind == KIND_END) ||
      (push.count == 2'd2 && push.second.kind == KIND_END))
    else $error("end of text without end token");

  // only the final token of a character is marked last
  assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> !push.first.last && push.second.last)
    else $error("last_of_run misplaced on a token pair");

  // an empty queue must accept characters
  assert property (@(posedge clk) disable iff (rst) !token_out.valid |-> char_in.ready)
    else $error("empty token queue refuses characters");

endmodule

### dv/char_stream_tokenizer_test.sv
// char_stream_tokenizer_test: self-checking bench for the streaming tokenizer, with a
// directed table, a length saturation run and random token-shaped text checked by a predictor
// depends on cst_pkg, cst_in_if, cst_out_if and char_stream_tokenizer
`timescale 1ns / 1ps

module char_stream_tokenizer_test;
  import cst_pkg::*;

  // kinds the package leaves unnamed
  localparam logic [4:0] KIND_LE    = 5'd15;
  localparam logic [4:0] KIND_LT    = 5'd16;
  localparam logic [4:0] KIND_GE    = 5'd17;
  localparam logic [4:0] KIND_GT    = 5'd18;
  localparam logic [4:0] KIND_NE    = 5'd19;
  localparam logic [4:0] KIND_NOT   = 5'd20;
  localparam logic [4:0] KIND_PRINT = 5'd22;
  localparam logic [4:0] KIND_IF    = 5'd23;
  localparam logic [4:0] KIND_ELSE  = 5'd24;

  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int RANDOM_ITEMS    = 620;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 5000;

  // character pools for the random text
  localparam logic [8*11-1:0] SINGLE_CHARS = "()[]{};+-*/";
  localparam logic [8*4-1:0]  OPENING_OPS  = "=<>!";
  localparam logic [8*13-1:0] ODD_CHARS    = "#$%&',:?@^`|~";
  localparam logic [8*6-1:0]  SPACE_CHARS  = {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  // digits sit at indexes 0..9, underscore at 10, letters at 11..62
  localparam logic [8*63-1:0] WORD_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  typedef struct packed {
    logic [7:0] c;
    logic       eot;
  } char_req_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eot;
    logic       typed;
    token_t     want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cst_in_if  char_in ();
  cst_out_if token_out ();

  char_stream_tokenizer u_top (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .token_out (token_out)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  token_t    tokens_due[$];
  token_t    item_tokens[$];
  char_req_t script[$];
  token_t    arrived_want;

  int   mismatch_count = 0;
  int   tokens_checked = 0;
  int   chars_sent = 0;
  int   random_sent = 0;
  int   burst_left = 0;
  logic hold_off_due = 1'b0;

  // predictor state
  scan_mode_t               lx_mode;
  logic                     lx_dot;
  logic [2:0]               lx_kw;
  logic [POSITION_BITS-1:0] lx_line;
  logic [POSITION_BITS-1:0] lx_col;
  logic [POSITION_BITS-1:0] lx_tok_line;
  logic [POSITION_BITS-1:0] lx_tok_col;
  logic [LENGTH_BITS-1:0]   lx_len;

  // directed table; rows with typed set carry the one token they must produce
  script_row_t directed_rows [0:24] = '{
    '{"(",   1'b0, 1'b1, '{KIND_LPAREN,  16'd1, 16'd1, 8'd1, 8'h00, 1'b1}},
    '{8'hFF, 1'b0, 1'b1, '{KIND_UNKNOWN, 16'd1, 16'd2, 8'd1, 8'hFF, 1'b1}},
    '{8'h80, 1'b0, 1'b1, '{KIND_UNKNOWN, 16'd1, 16'd3, 8'd1, 8'h80, 1'b1}},
    '{8'h7F, 1'b0, 1'b1, '{KIND_UNKNOWN, 16'd1, 16'd4, 8'd1, 8'h7F, 1'b1}},
    '{"<",   1'b0, 1'b0, '0},
    '{"=",   1'b0, 1'b1, '{KIND_LE,      16'd1, 16'd5, 8'd2, 8'h00, 1'b1}},
    '{"!",   1'b0, 1'b0, '0},
    '{"p",   1'b0, 1'b0, '0},
    '{"r",   1'b0, 1'b0, '0},
    '{"i",   1'b0, 1'b0, '0},
    '{"n",   1'b0, 1'b0, '0},
    '{"t",   1'b0, 1'b0, '0},
    '{".",   1'b0, 1'b0, '0},
    '{".",   1'b0, 1'b0, '0},
    '{"7",   1'b0, 1'b0, '0},
    '{".",   1'b0, 1'b0, '0},
    '{CH_LF, 1'b0, 1'b0, '0},
    '{"e",   1'b0, 1'b0, '0},
    '{"l",   1'b0, 1'b0, '0},
    '{"s",   1'b0, 1'b0, '0},
    '{"e",   1'b0, 1'b0, '0},
    '{CH_NUL, 1'b0, 1'b0, '0},
    '{"x",   1'b1, 1'b1, '{KIND_END,     16'd1, 16'd1, 8'd0, 8'h00, 1'b1}},
    '{">",   1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0}
  };

  // keyword spelling, NUL past the end of the word
  function automatic logic [7:0] keyword_letter(input logic [2:0] prog, input int idx);
    logic [39:0] w;
    int n;
    case (prog)
      KW_PRINT: begin
        w = "print";
        n = 5;
      end
      KW_IF: begin
        w = "if";
        n = 2;
      end
      KW_ELSE: begin
        w = "else";
        n = 4;
      end
      default: begin
        w = '0;
        n = 0;
      end
    endcase
    if (idx < 0 || idx >= n) return CH_NUL;
    return w[8*(n-1-idx) +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [4:0] operator_kind(input scan_mode_t mode, input logic paired);
    case (mode)
      MODE_OP_EQ: return paired ? KIND_EQ_EQ : KIND_ASSIGN;
      MODE_OP_LT: return paired ? KIND_LE : KIND_LT;
      MODE_OP_GT: return paired ? KIND_GE : KIND_GT;
      default:    return paired ? KIND_NE : KIND_NOT;
    endcase
  endfunction

  function automatic void scanner_reset();
    lx_mode     = MODE_IDLE;
    lx_dot      = 1'b0;
    lx_kw       = KW_NONE;
    lx_line     = POS_ONE;
    lx_col      = POS_ONE;
    lx_tok_line = POS_ONE;
    lx_tok_col  = POS_ONE;
    lx_len      = '0;
  endfunction

  // line and column after consuming one character, both saturating
  function automatic void step_position(input logic [7:0] c);
    if (c == CH_LF) begin
      if (lx_line != POS_MAX) lx_line++;
      lx_col = POS_ONE;
    end else if (lx_col != POS_MAX) begin
      lx_col++;
    end
  endfunction

  function automatic void add_token(input logic [4:0] kind, input logic [POSITION_BITS-1:0] line,
                                    input logic [POSITION_BITS-1:0] col, input logic [7:0] len,
                                    input logic [7:0] bad);
    token_t t;
    t = '{kind, line, col, len, bad, 1'b0};
    if (item_tokens.size() < 2) item_tokens = {item_tokens, t};
  endfunction

  function automatic void open_token(input scan_mode_t mode);
    lx_mode     = mode;
    lx_tok_line = lx_line;
    lx_tok_col  = lx_col;
    lx_len      = LEN_ONE;
  endfunction

  function automatic void lengthen(input logic [7:0] c);
    if (lx_len != LEN_MAX) lx_len++;
    step_position(c);
  endfunction

  // emit whatever token is still open and go idle
  function automatic void close_token();
    logic [4:0] kind;
    case (lx_mode)
      MODE_NUMBER: add_token(KIND_NUMBER, lx_tok_line, lx_tok_col, lx_len, CH_NUL);
      MODE_WORD: begin
        // a live keyword prefix that spans the whole keyword is the keyword
        kind = KIND_IDENT;
        if (lx_kw != KW_NONE && keyword_letter(lx_kw, int'(lx_len)) == CH_NUL) begin
          case (lx_kw)
            KW_PRINT: kind = KIND_PRINT;
            KW_IF:    kind = KIND_IF;
            default:  kind = KIND_ELSE;
          endcase
        end
        add_token(kind, lx_tok_line, lx_tok_col, lx_len, CH_NUL);
      end
      MODE_DOT: add_token(KIND_UNKNOWN, lx_tok_line, lx_tok_col, 8'd1, CH_DOT);
      MODE_OP_EQ, MODE_OP_LT, MODE_OP_GT, MODE_OP_NOT:
        add_token(operator_kind(lx_mode, 1'b0), lx_tok_line, lx_tok_col, 8'd1, CH_NUL);
      default: ;
    endcase
    lx_mode = MODE_IDLE;
    lx_dot  = 1'b0;
    lx_kw   = KW_NONE;
    lx_len  = '0;
  endfunction

  // a character seen with nothing open
  function automatic void scan_fresh(input logic [7:0] c);
    logic [4:0] single;
    case (c)
      "(":     single = KIND_LPAREN;
      ")":     single = KIND_RPAREN;
      "[":     single = KIND_LBRACK;
      "]":     single = KIND_RBRACK;
      "{":     single = KIND_LBRACE;
      "}":     single = KIND_RBRACE;
      ";":     single = KIND_SEMI;
      "+":     single = KIND_PLUS;
      "-":     single = KIND_MINUS;
      "*":     single = KIND_STAR;
      "/":     single = KIND_SLASH;
      default: single = KIND_END;
    endcase
    if (single != KIND_END) begin
      add_token(single, lx_line, lx_col, 8'd1, CH_NUL);
    end else if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
      // whitespace only moves the position
    end else if (c == CH_EQ) begin
      open_token(MODE_OP_EQ);
    end else if (c == CH_LT) begin
      open_token(MODE_OP_LT);
    end else if (c == CH_GT) begin
      open_token(MODE_OP_GT);
    end else if (c == CH_BANG) begin
      open_token(MODE_OP_NOT);
    end else if (is_digit(c)) begin
      open_token(MODE_NUMBER);
      lx_dot = 1'b0;
    end else if (c == CH_DOT) begin
      open_token(MODE_DOT);
    end else if (is_letter(c) || c == CH_UNDER) begin
      open_token(MODE_WORD);
      lx_kw = (c == "p") ? KW_PRINT : (c == "i") ? KW_IF : (c == "e") ? KW_ELSE : KW_NONE;
    end else begin
      add_token(KIND_UNKNOWN, lx_line, lx_col, 8'd1, c);
    end
    step_position(c);
  endfunction

  // tokens caused by one accepted character request, left in item_tokens
  function automatic void lex_char(input logic [7:0] c, input logic eot);
    item_tokens.delete();
    if (eot || c == CH_NUL) begin
      close_token();
      add_token(KIND_END, lx_line, lx_col, 8'd0, CH_NUL);
      scanner_reset();
    end else if (lx_mode == MODE_NUMBER && (is_digit(c) || (c == CH_DOT && !lx_dot))) begin
      if (c == CH_DOT) lx_dot = 1'b1;
      lengthen(c);
    end else if (lx_mode == MODE_WORD && (is_letter(c) || is_digit(c) || c == CH_UNDER)) begin
      if (lx_kw != KW_NONE && keyword_letter(lx_kw, int'(lx_len)) != c) lx_kw = KW_NONE;
      lengthen(c);
    end else if (lx_mode == MODE_DOT && is_digit(c)) begin
      lx_mode = MODE_NUMBER;
      lx_dot  = 1'b1;
      lengthen(c);
    end else if ((lx_mode == MODE_OP_EQ || lx_mode == MODE_OP_LT || lx_mode == MODE_OP_GT ||
                  lx_mode == MODE_OP_NOT) && c == CH_EQ) begin
      add_token(operator_kind(lx_mode, 1'b1), lx_tok_line, lx_tok_col, 8'd2, CH_NUL);
      lx_mode = MODE_IDLE;
      lx_len  = '0;
      step_position(c);
    end else begin
      close_token();
      scan_fresh(c);
    end
    if (item_tokens.size() != 0) item_tokens[item_tokens.size()-1].last = 1'b1;
  endfunction

  // sender: bursts of requests with random gaps between them
  task automatic offer_char(input logic [7:0] c, input logic eot, input logic typed,
                            input token_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        char_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    char_in.valid       <= 1'b1;
    char_in.text_byte   <= c;
    char_in.end_of_text <= eot;
    @(posedge clk);
    while (!char_in.ready) @(posedge clk);
    burst_left--;
    chars_sent++;
    lex_char(c, eot);
    if (typed) begin
      tokens_due = {tokens_due, want};
    end else begin
      foreach (item_tokens[k]) tokens_due = {tokens_due, item_tokens[k]};
    end
  endtask

  function automatic void add_char(input logic [7:0] c);
    script = {script, char_req_t'{c, 1'b0}};
  endfunction

  function automatic logic [7:0] any_of(input int lo, input int hi);
    int k;
    k = $urandom_range(lo, hi);
    return WORD_CHARS[8*k +: 8];
  endfunction

  // one token-shaped fragment of random text, sometimes noise or an end of text
  task automatic compose_fragment();
    int pick;
    int n;
    int k;
    logic [2:0] kw;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      k = $urandom_range(0, 10);
      add_char(SINGLE_CHARS[8*k +: 8]);
    end else if (pick < 24) begin
      k = $urandom_range(0, 3);
      add_char(OPENING_OPS[8*k +: 8]);
      if ($urandom_range(0, 1) == 1) add_char(CH_EQ);
    end else if (pick < 40) begin
      // number, sometimes with a fraction or a stray second dot
      n = $urandom_range(1, 5);
      repeat (n) add_char(any_of(0, 9));
      if ($urandom_range(0, 2) == 0) begin
        add_char(CH_DOT);
        n = $urandom_range(0, 3);
        repeat (n) add_char(any_of(0, 9));
        if ($urandom_range(0, 3) == 0) begin
          add_char(CH_DOT);
          n = $urandom_range(0, 2);
          repeat (n) add_char(any_of(0, 9));
        end
      end
    end else if (pick < 46) begin
      // leading dot, a number only when a digit follows
      add_char(CH_DOT);
      if ($urandom_range(0, 1) == 1) begin
        n = $urandom_range(1, 3);
        repeat (n) add_char(any_of(0, 9));
      end
    end else if (pick < 64) begin
      kw = 3'($urandom_range(1, 3));
      n = 0;
      while (keyword_letter(kw, n) != CH_NUL) n++;
      case ($urandom_range(0, 3))
        0: for (k = 0; k < n; k++) add_char(keyword_letter(kw, k));
        1: begin
          n = $urandom_range(1, n - 1);
          for (k = 0; k < n; k++) add_char(keyword_letter(kw, k));
        end
        2: begin
          for (k = 0; k < n; k++) add_char(keyword_letter(kw, k));
          add_char(any_of(0, 62));
        end
        default: begin
          n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
          add_char(any_of(10, 62));
          for (k = 1; k < n; k++) add_char(any_of(0, 62));
        end
      endcase
    end else if (pick < 82) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        k = $urandom_range(0, 5);
        add_char(SPACE_CHARS[8*k +: 8]);
      end
    end else if (pick < 88) begin
      // bytes with no meaning to the scanner
      case ($urandom_range(0, 3))
        0: add_char(8'($urandom_range(128, 255)));
        1: add_char(8'($urandom_range(1, 8)));
        2: add_char(8'($urandom_range(14, 31)));
        default: begin
          k = $urandom_range(0, 12);
          add_char(ODD_CHARS[8*k +: 8]);
        end
      endcase
    end else if (pick < 95) begin
      add_char(8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 1) == 1) begin
      script = {script, char_req_t'{8'($urandom_range(0, 255)), 1'b1}};
    end else begin
      add_char(CH_NUL);
    end
  endtask

  // receiver: its own stall pattern, with a long hold-off on request
  initial begin
    token_out.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        token_out.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        token_out.ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        token_out.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        token_out.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each token request with the oldest prediction
  always @(posedge clk) begin
    if (!rst && token_out.valid && token_out.ready) begin
      tokens_checked++;
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected token, expected none, got kind %0d at %0d:%0d", $time,
                 token_out.token_kind, token_out.token_line, token_out.start_column);
        mismatch_count++;
      end else begin
        arrived_want = tokens_due.pop_front();
        check_field("token_kind", 32'(arrived_want.kind), 32'(token_out.token_kind));
        check_field("token_line", 32'(arrived_want.line), 32'(token_out.token_line));
        check_field("start_column", 32'(arrived_want.column), 32'(token_out.start_column));
        check_field("lexeme_length", 32'(arrived_want.length),
                    32'(token_out.lexeme_length));
        check_field("unknown_byte", 32'(arrived_want.bad_byte), 32'(token_out.unknown_byte));
        check_field("last_of_run", 32'(arrived_want.last), 32'(token_out.last_of_run));
      end
    end
  end

  // run limit
  initial begin
    #40_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus and end of run
  initial begin
    char_req_t req;
    int waited;
    char_in.valid       = 1'b0;
    char_in.text_byte   = 8'h00;
    char_in.end_of_text = 1'b0;
    scanner_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      offer_char(directed_rows[i].c, directed_rows[i].eot, directed_rows[i].typed,
                 directed_rows[i].want);
    end

    // lexeme length saturation
    repeat (300) offer_char("a", 1'b0, 1'b0, '0);
    offer_char(CH_SPACE, 1'b0, 1'b0, '0);
    offer_char("+", 1'b0, 1'b0, '0);
    offer_char(8'hA5, 1'b1, 1'b0, '0);

    // random text, with the receiver holding off twice so the block backs up
    hold_off_due = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      compose_fragment();
      while (script.size() != 0) begin
        req = script.pop_front();
        offer_char(req.c, req.eot, 1'b0, '0);
        random_sent++;
        if (random_sent == RANDOM_ITEMS / 2) hold_off_due = 1'b1;
      end
    end
    char_in.valid <= 1'b0;

    // drain and settle
    waited = 0;
    while (tokens_due.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (tokens_due.size() != 0) begin
      $display("%0t: %0d expected tokens never arrived", $time, tokens_due.size());
      mismatch_count += tokens_due.size();
    end

    $display("sent %0d characters: directed cases, lexeme length saturation, %0d random",
             chars_sent, random_sent);
    $display("compared %0d tokens against the predicted stream, %0d mismatches",
             tokens_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
